### rtl/double_ended_queue_unit_macros.svh
// ============================================================================
// Double-ended queue unit: assertion macros
// Shared concurrent assertion forms used by the port checker.
// ============================================================================
`ifndef DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DEQU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DEQU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/dequ_pkg.sv
// ============================================================================
// Double-ended queue unit: package
// Widths, operation and status codes, and the command broadcast to the cells.
// ============================================================================
`default_nettype none

package dequ_pkg;

    localparam int DATA_W        = 64;
    localparam int OP_W          = 3;
    localparam int ST_W          = 2;
    localparam int DEPTH_DEFAULT = 1024;

    // Operation codes carried on the input tuser.
    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_PEEK_FRONT = 3'd4,
        OP_PEEK_BACK  = 3'd5,
        OP_SIZE       = 3'd6,
        OP_CLEAR      = 3'd7
    } op_t;

    // Status codes carried on the output tuser.
    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_VALUE = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    // The mode applied to every cell of one row in a cycle.
    typedef enum logic [1:0] {
        ROW_HOLD      = 2'd0,
        ROW_SHIFT_IN  = 2'd1,
        ROW_SHIFT_OUT = 2'd2,
        ROW_WRITE     = 2'd3
    } row_mode_t;

    typedef struct packed {
        row_mode_t                 mode;
        logic signed [DATA_W-1:0] value;
    } row_cmd_t;

endpackage

`default_nettype wire

### rtl/double_ended_queue_unit.sv
// A result appears on the master side in the cycle after its request is taken.
// Throughput: one request per cycle, every operation alike, while results are taken.
// Each operation moves each cell row by at most one position.
// Reset clears the fill count and the output valid flag; entry storage is not cleared.
// The input stalls only while a result waits and the output is not ready.
// ============================================================================
// Double-ended queue unit: top level
// Two rows of cells hold the same entries: the front row from the front end,
// the back row from the back end. Both ends are always read at cell zero.
// ============================================================================
`default_nettype none

module double_ended_queue_unit
    import dequ_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // push_value [63:0]
    input  wire logic [DATA_W-1:0]     s_axis_tdata,
    // operation [2:0]
    input  wire logic [OP_W-1:0]       s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // read_value [63:0], count above it, zero fill to whole bytes
    output logic [((DATA_W + $clog2(DEPTH + 1) + 7) / 8) * 8 - 1:0] m_axis_tdata,
    // status [1:0]
    output logic [ST_W-1:0]            m_axis_tuser
);

    localparam int CW    = $clog2(DEPTH + 1);
    localparam int OUT_W = ((DATA_W + CW + 7) / 8) * 8;

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    logic                 out_valid_reg;
    logic [OUT_W-1:0]     out_data_reg;
    logic [ST_W-1:0]      out_user_reg;

    logic                     accept;
    op_t                      op;
    logic                     empty;
    logic                     full;
    status_t                  status;
    logic signed [DATA_W-1:0] read_value;
    row_cmd_t                 front_cmd;
    row_cmd_t                 back_cmd;

    logic signed [DATA_W-1:0] front_data  [DEPTH];
    logic signed [DATA_W-1:0] back_data   [DEPTH];
    logic signed [DATA_W-1:0] front_left  [DEPTH];
    logic signed [DATA_W-1:0] front_right [DEPTH];
    logic signed [DATA_W-1:0] back_left   [DEPTH];
    logic signed [DATA_W-1:0] back_right  [DEPTH];
    logic [DEPTH-1:0]         wr_sel;

    assign accept = s_axis_tvalid && s_axis_tready;
    assign op     = op_t'(s_axis_tuser);
    assign empty  = (count_reg == '0);
    assign full   = (count_reg == CW'(DEPTH));

    // The input is taken whenever the output register is free or being emptied.
    assign s_axis_tready = !out_valid_reg || m_axis_tready;

    // Decode the request into row commands, status, read value and new count.
    always_comb
    begin
        front_cmd.mode  = ROW_HOLD;
        front_cmd.value = $signed(s_axis_tdata);
        back_cmd.mode   = ROW_HOLD;
        back_cmd.value  = $signed(s_axis_tdata);
        status          = ST_OK;
        read_value      = '0;
        count_next      = count_reg;
        case (op)
            OP_PUSH_FRONT:
            begin
                if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    front_cmd.mode = ROW_SHIFT_IN;
                    back_cmd.mode  = ROW_WRITE;
                    count_next     = count_reg + CW'(1);
                end
            end
            OP_PUSH_BACK:
            begin
                if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    back_cmd.mode  = ROW_SHIFT_IN;
                    front_cmd.mode = ROW_WRITE;
                    count_next     = count_reg + CW'(1);
                end
            end
            OP_POP_FRONT, OP_PEEK_FRONT:
            begin
                if (empty)
                begin
                    status = ST_EMPTY;
                end
                else
                begin
                    status     = ST_VALUE;
                    read_value = front_data[0];
                    if (op == OP_POP_FRONT)
                    begin
                        front_cmd.mode = ROW_SHIFT_OUT;
                        count_next     = count_reg - CW'(1);
                    end
                end
            end
            OP_POP_BACK, OP_PEEK_BACK:
            begin
                if (empty)
                begin
                    status = ST_EMPTY;
                end
                else
                begin
                    status     = ST_VALUE;
                    read_value = back_data[0];
                    if (op == OP_POP_BACK)
                    begin
                        back_cmd.mode = ROW_SHIFT_OUT;
                        count_next    = count_reg - CW'(1);
                    end
                end
            end
            OP_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                status = ST_OK;
            end
        endcase
        if (!accept)
        begin
            front_cmd.mode = ROW_HOLD;
            back_cmd.mode  = ROW_HOLD;
        end
    end

    // Two rows of cells with neighbor links; the end cells see the push value
    // or themselves.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        assign wr_sel[i] = (count_reg == CW'(i));

        if (i == 0)
        begin : g_first
            assign front_left[i] = front_cmd.value;
            assign back_left[i]  = back_cmd.value;
        end
        else
        begin : g_inner_left
            assign front_left[i] = front_data[i-1];
            assign back_left[i]  = back_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign front_right[i] = front_data[i];
            assign back_right[i]  = back_data[i];
        end
        else
        begin : g_inner_right
            assign front_right[i] = front_data[i+1];
            assign back_right[i]  = back_data[i+1];
        end

        dequ_cell u_front_cell (
            .clk        (clk),
            .cmd        (front_cmd),
            .write_en   (wr_sel[i]),
            .left_data  (front_left[i]),
            .right_data (front_right[i]),
            .data       (front_data[i])
        );

        dequ_cell u_back_cell (
            .clk        (clk),
            .cmd        (back_cmd),
            .write_en   (wr_sel[i]),
            .left_data  (back_left[i]),
            .right_data (back_right[i]),
            .data       (back_data[i])
        );
    end

    // Fill count and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= OUT_W'({count_next, read_value});
            out_user_reg <= status;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

endmodule

`default_nettype wire

### rtl/dequ_cell.sv
// ============================================================================
// Double-ended queue unit: storage cell
// Holds one entry of a row; takes a neighbor's entry when the row shifts, or
// the broadcast value when the row writes at this cell's position.
// ============================================================================
`default_nettype none

module dequ_cell
    import dequ_pkg::*;
(
    input  wire logic                     clk,
    input  wire row_cmd_t                 cmd,
    input  wire logic                     write_en,
    input  wire logic signed [DATA_W-1:0] left_data,
    input  wire logic signed [DATA_W-1:0] right_data,
    output logic signed [DATA_W-1:0]      data
);

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;

    // Select the new entry for this cell.
    always_comb
    begin
        case (cmd.mode)
            ROW_SHIFT_IN:  data_next = left_data;
            ROW_SHIFT_OUT: data_next = right_data;
            ROW_WRITE:     data_next = write_en ? cmd.value : data_reg;
            default:       data_next = data_reg;
        endcase
    end

    // Entry storage; contents are meaningful only below the fill count.
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

`default_nettype wire

### rtl/dequ_checker.sv
// ============================================================================
// Double-ended queue unit: port checker
// Watches the top-level ports and checks result consistency over time.
// ============================================================================
`default_nettype none

`include "double_ended_queue_unit_macros.svh"

module dequ_checker
    import dequ_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  s_axis_tvalid,
    input wire logic                  s_axis_tready,
    input wire logic                  m_axis_tvalid,
    input wire logic                  m_axis_tready,
    // read_value [63:0], count above it
    input wire logic [((DATA_W + $clog2(DEPTH + 1) + 7) / 8) * 8 - 1:0] m_axis_tdata,
    // status [1:0]
    input wire logic [ST_W-1:0]       m_axis_tuser
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0]     res_count;
    logic [DATA_W-1:0] res_value;
    logic              in_req;

    assign res_count = m_axis_tdata[DATA_W +: CW];
    assign res_value = m_axis_tdata[DATA_W-1:0];
    assign in_req    = s_axis_tvalid && s_axis_tready;

    // A stalled result holds its payload.
    `DEQU_ASSERT_NEXT(a_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result not held")

    // Every accepted request yields a result in the next cycle.
    `DEQU_ASSERT_NEXT(a_result, clk, rst_n, in_req, m_axis_tvalid, "result missing")

    // The reported count never exceeds the capacity.
    `DEQU_ASSERT_NOW(a_count_max, clk, rst_n, m_axis_tvalid,
        res_count <= CW'(DEPTH), "count above capacity")

    // An empty error reports zero entries, a full rejection reports capacity.
    `DEQU_ASSERT_NOW(a_status_count, clk, rst_n,
        m_axis_tvalid && (m_axis_tuser == ST_EMPTY || m_axis_tuser == ST_FULL),
        (m_axis_tuser == ST_EMPTY) ? (res_count == '0) : (res_count == CW'(DEPTH)),
        "status disagrees with count")

    // Only a value-returning status carries a nonzero value.
    `DEQU_ASSERT_NOW(a_value_zero, clk, rst_n, m_axis_tvalid && m_axis_tuser != ST_VALUE,
        res_value == '0, "value without value status")

endmodule

bind double_ended_queue_unit dequ_checker #(.DEPTH(DEPTH)) u_dequ_checker (.*);

`default_nettype wire
